@@ rtl/core/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted table search package
// Shared sizes, status codes, controller states and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sts_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int IDX_W       = 10;
    localparam int ENTRY_W     = 11;
    localparam int CMP_W       = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
    localparam int IDXX_W      = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

    localparam logic [ENTRY_W-1:0] ENTRY_RESET = ENTRY_W'(1024);

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t STS_LOADED  = 2'd0;
    localparam status_t STS_REFUSED = 2'd1;
    localparam status_t STS_FOUND   = 2'd2;
    localparam status_t STS_MISSING = 2'd3;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_STEP,
        S_LD_CMP,
        S_Q_STEP,
        S_Q_CMP,
        S_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    start;      // capture the word, init pointers
        logic    rd_load;    // read entry below the insert slot
        logic    wr_shift;   // move read entry up one slot
        logic    wr_key;     // write key at insert slot, bump count
        logic    rd_query;   // read midpoint, latch it
        logic    lo_up;      // lo = mid + 1
        logic    hi_down;    // hi = mid
        logic    set_res;    // latch a result code
        status_t res_code;
        logic    emit;       // move result into output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;          // table holds its capacity
        logic pos_zero;      // insert slot at bottom
        logic range_empty;   // search window empty
        logic key_lt_rd;     // key < read entry
        logic rd_eq;         // read entry == key
        logic rd_lt_key;     // read entry < key
        logic out_free;      // output register can take a word
    } stat_t;

    // Fit a table address into the index field (low bits, zero extended)
    function automatic logic [IDX_W-1:0] to_index(input logic [ADDR_W-1:0] a);
        logic [IDXX_W-1:0] t;
        t = IDXX_W'(a);
        return t[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/core/sts_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/sts_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted table search controller
// Sequences insert shifts and binary search probes, hands results to output.
// ----------------------------------------------------------------------------
module sts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           req_type,
    output logic           in_ready,
    input  sts_pkg::stat_t stat,
    output sts_pkg::cmd_t  cmd
);

    sts_pkg::state_t state_reg;
    sts_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_code = sts_pkg::STS_MISSING;
        in_ready     = 1'b0;
        case (state_reg)
            sts_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (req_type == sts_pkg::REQ_QUERY)
                    begin
                        state_next = sts_pkg::S_Q_STEP;
                    end
                    else
                    begin
                        state_next = sts_pkg::S_LD_STEP;
                    end
                end
            end
            sts_pkg::S_LD_STEP:
            begin
                if (stat.full)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = sts_pkg::STS_REFUSED;
                    state_next   = sts_pkg::S_DONE;
                end
                else if (stat.pos_zero)
                begin
                    cmd.wr_key   = 1'b1;
                    cmd.set_res  = 1'b1;
                    cmd.res_code = sts_pkg::STS_LOADED;
                    state_next   = sts_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd_load = 1'b1;
                    state_next  = sts_pkg::S_LD_CMP;
                end
            end
            sts_pkg::S_LD_CMP:
            begin
                // shift larger entry up, or drop the key into place
                if (stat.key_lt_rd)
                begin
                    cmd.wr_shift = 1'b1;
                    state_next   = sts_pkg::S_LD_STEP;
                end
                else
                begin
                    cmd.wr_key   = 1'b1;
                    cmd.set_res  = 1'b1;
                    cmd.res_code = sts_pkg::STS_LOADED;
                    state_next   = sts_pkg::S_DONE;
                end
            end
            sts_pkg::S_Q_STEP:
            begin
                if (stat.range_empty)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = sts_pkg::STS_MISSING;
                    state_next   = sts_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd_query = 1'b1;
                    state_next   = sts_pkg::S_Q_CMP;
                end
            end
            sts_pkg::S_Q_CMP:
            begin
                if (stat.rd_eq)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = sts_pkg::STS_FOUND;
                    state_next   = sts_pkg::S_DONE;
                end
                else if (stat.rd_lt_key)
                begin
                    cmd.lo_up  = 1'b1;
                    state_next = sts_pkg::S_Q_STEP;
                end
                else
                begin
                    cmd.hi_down = 1'b1;
                    state_next  = sts_pkg::S_Q_STEP;
                end
            end
            sts_pkg::S_DONE:
            begin
                // hold until the output register frees up
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/sts_dpath.sv @@
// ----------------------------------------------------------------------------
// Sorted table search datapath
// Key store, fill count, insert pointer, search window, compares and the
// output register.
// ----------------------------------------------------------------------------
module sts_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sts_pkg::ENTRY_W-1:0]         cfg_wr_data,
    input  logic                                req_type,
    input  logic signed [sts_pkg::KEY_W-1:0]    key,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [1:0]                          status,
    output logic [sts_pkg::IDX_W-1:0]           index,
    input  sts_pkg::cmd_t                       cmd,
    output sts_pkg::stat_t                      stat
);

    logic [sts_pkg::ENTRY_W-1:0]      entry_count_reg;
    logic [sts_pkg::CNT_W-1:0]        count_reg;
    logic [sts_pkg::CNT_W-1:0]        pos_reg;
    logic [sts_pkg::CNT_W-1:0]        lo_reg;
    logic [sts_pkg::CNT_W-1:0]        hi_reg;      // exclusive upper bound
    logic [sts_pkg::ADDR_W-1:0]       mid_reg;
    logic signed [sts_pkg::KEY_W-1:0] key_reg;
    sts_pkg::status_t                 res_status_reg;
    logic [sts_pkg::IDX_W-1:0]        res_index_reg;
    logic                             out_valid_reg;
    sts_pkg::status_t                 status_reg;
    logic [sts_pkg::IDX_W-1:0]        index_reg;

    logic [sts_pkg::CNT_W-1:0]        pos_dec;
    logic [sts_pkg::CNT_W-1:0]        mid_full;
    logic [sts_pkg::CMP_W-1:0]        count_x;
    logic signed [sts_pkg::KEY_W-1:0] rd_key;
    logic [sts_pkg::KEY_W-1:0]        rd_data;
    logic                             ram_wr_en;
    logic [sts_pkg::ADDR_W-1:0]       ram_wr_addr;
    logic [sts_pkg::KEY_W-1:0]        ram_wr_data;
    logic                             ram_rd_en;
    logic [sts_pkg::ADDR_W-1:0]       ram_rd_addr;

    // Pointer arithmetic
    assign pos_dec  = pos_reg - 1'b1;
    assign mid_full = lo_reg + ((hi_reg - 1'b1 - lo_reg) >> 1);
    assign count_x  = sts_pkg::CMP_W'(count_reg);
    assign rd_key   = $signed(rd_data);

    // Status back to the controller
    always_comb
    begin
        stat.full        = (count_x >= sts_pkg::CMP_W'(entry_count_reg))
                        || (count_x >= sts_pkg::CMP_W'(sts_pkg::TABLE_DEPTH));
        stat.pos_zero    = (pos_reg == '0);
        stat.range_empty = !(lo_reg < hi_reg);
        stat.key_lt_rd   = (key_reg < rd_key);
        stat.rd_eq       = (rd_key == key_reg);
        stat.rd_lt_key   = (rd_key < key_reg);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    // Key store port steering
    always_comb
    begin
        ram_wr_en   = cmd.wr_shift || cmd.wr_key;
        ram_wr_addr = pos_reg[sts_pkg::ADDR_W-1:0];
        ram_wr_data = cmd.wr_shift ? rd_data : key_reg;
        ram_rd_en   = cmd.rd_load || cmd.rd_query;
        ram_rd_addr = cmd.rd_query ? mid_full[sts_pkg::ADDR_W-1:0]
                                   : pos_dec[sts_pkg::ADDR_W-1:0];
    end

    sts_ram #(
        .WIDTH (sts_pkg::KEY_W),
        .DEPTH (sts_pkg::TABLE_DEPTH)
    ) u_keys (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    // Configuration and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= sts_pkg::ENTRY_RESET;
            count_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                entry_count_reg <= cfg_wr_data;
            end
            if (cmd.wr_key)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Working registers for the current word
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= key;
            pos_reg <= count_reg;
            lo_reg  <= '0;
            hi_reg  <= (req_type == sts_pkg::REQ_QUERY) ? count_reg : '0;
        end
        if (cmd.wr_shift)
        begin
            pos_reg <= pos_dec;
        end
        if (cmd.rd_query)
        begin
            mid_reg <= mid_full[sts_pkg::ADDR_W-1:0];
        end
        if (cmd.lo_up)
        begin
            lo_reg <= sts_pkg::CNT_W'(mid_reg) + 1'b1;
        end
        if (cmd.hi_down)
        begin
            hi_reg <= sts_pkg::CNT_W'(mid_reg);
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_code;
            res_index_reg  <= (cmd.res_code == sts_pkg::STS_FOUND)
                            ? sts_pkg::to_index(mid_reg) : '0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg <= res_status_reg;
            index_reg  <= res_index_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign index     = index_reg;

endmodule

@@ rtl/core/sorted_table_binary_search_unit.sv @@
// ----------------------------------------------------------------------------
// Sorted table binary search unit
// Keeps signed keys in ascending order; loads insert in place, queries run a
// binary search over the loaded entries.
//
//   Channel  Direction  Signals
//   in       sink       in_valid, in_ready, req_type, key
//   out      source     out_valid, out_ready, status, index
//   cfg      sink       cfg_wr_en, cfg_wr_data (entry_count)
//
// A load reads the entry below the insert slot, shifts it up one slot while
// it is larger than the key, and then writes the key into the freed slot; a
// load into a full table is refused. A query probes the window midpoint and
// narrows the window until a probe hits or the window is empty. Each shift or
// probe is one read and one compare/write of the single key store. Reset
// clears the fill count and sets entry_count to 1024; the key store needs no
// clearing. A stalled output holds one word while the next word is accepted
// and worked on.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             req_type,
    input  logic signed [sts_pkg::KEY_W-1:0] key,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [sts_pkg::IDX_W-1:0]        index,
    input  logic                             cfg_wr_en,
    input  logic [sts_pkg::ENTRY_W-1:0]      cfg_wr_data
);

    sts_pkg::cmd_t  cmd;
    sts_pkg::stat_t stat;

    // Sequencer
    sts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and compares
    sts_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_type    (req_type),
        .key         (key),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .status      (status),
        .index       (index),
        .cmd         (cmd),
        .stat        (stat)
    );

`ifndef SYNTH
    // An accepted word keeps the sequencer busy next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after an accepted word");

    // Index is zero unless a query hit
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != sts_pkg::STS_FOUND |-> index == '0)
        else $error("nonzero index on a non-found result");

    // Never write a key into a full table
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_key |-> !stat.full)
        else $error("key written while table full");

    // Never probe an empty search window
    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_query |-> !stat.range_empty)
        else $error("probe issued on empty window");
`endif

endmodule
